// ===== hw/rtl/datapoint_tlv_parser_macros.svh =====
// assertion macros for the datapoint tlv parser
// used by datapoint_tlv_parser.sv, no other dependencies
`ifndef DATAPOINT_TLV_PARSER_MACROS_SVH
`define DATAPOINT_TLV_PARSER_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication under reset
`define DPTLV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication under reset
`define DPTLV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DPTLV_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define DPTLV_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/dptlv_pkg.sv =====
// shared types, constants and phase codes for the datapoint tlv parser
// no dependencies
package dptlv_pkg;

    localparam int MAX_DP_LENGTH     = 256;
    localparam int MAX_MESSAGE_BYTES = 1023;
    localparam int LEN_W             = 10;
    localparam int PH_W              = 3;

    localparam logic [PH_W-1:0] PH_IDLE  = 3'd0;
    localparam logic [PH_W-1:0] PH_SKIP  = 3'd1;
    localparam logic [PH_W-1:0] PH_ID    = 3'd2;
    localparam logic [PH_W-1:0] PH_TYPE  = 3'd3;
    localparam logic [PH_W-1:0] PH_LENHI = 3'd4;
    localparam logic [PH_W-1:0] PH_LENLO = 3'd5;
    localparam logic [PH_W-1:0] PH_DATA  = 3'd6;
    localparam logic [PH_W-1:0] PH_DROP  = 3'd7;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             first_byte;
        logic [LEN_W-1:0] message_length;
        logic             status_report;
    } item_t;

    typedef struct packed {
        logic [7:0]       dp_id;
        logic [7:0]       dp_type;
        logic [LEN_W-1:0] dp_length;
        logic [31:0]      dp_value;
        logic             bad_length;
    } result_t;

endpackage

// ===== hw/rtl/dptlv_in_if.sv =====
// valid/ready channel carrying one payload byte and its message markers
// depends on dptlv_pkg
interface dptlv_in_if
    import dptlv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [7:0]       data_byte;
    logic             first_byte;
    logic [LEN_W-1:0] message_length;
    logic             status_report;

    modport source (output valid, data_byte, first_byte, message_length, status_report,
                    input ready);
    modport sink   (input valid, data_byte, first_byte, message_length, status_report,
                    output ready);
endinterface

// ===== hw/rtl/dptlv_out_if.sv =====
// valid/ready channel carrying one parsed datapoint
// depends on dptlv_pkg
interface dptlv_out_if
    import dptlv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [7:0]       dp_id;
    logic [7:0]       dp_type;
    logic [LEN_W-1:0] dp_length;
    logic [31:0]      dp_value;
    logic             bad_length;

    modport source (output valid, dp_id, dp_type, dp_length, dp_value, bad_length,
                    input ready);
    modport sink   (input valid, dp_id, dp_type, dp_length, dp_value, bad_length,
                    output ready);
endinterface

// ===== hw/rtl/dptlv_in_reg.sv =====
// input register stage: holds one accepted word until the parser takes it
// depends on dptlv_pkg
module dptlv_in_reg
    import dptlv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  load,
    input  item_t item_in,
    input  logic  take,
    output logic  valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    assign valid_next = load | (valid_reg & ~take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign valid    = valid_reg;
    assign item_out = item_reg;

endmodule

// ===== hw/rtl/dptlv_parse.sv =====
// per-byte parse state machine: header fields, length checks, value capture
// depends on dptlv_pkg
module dptlv_parse
    import dptlv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    output logic    emit,
    output result_t res
);

    logic [PH_W-1:0]  phase_reg,  phase_next;
    logic [LEN_W-1:0] pos_reg,    pos_next;
    logic [LEN_W-1:0] total_reg,  total_next;
    logic [LEN_W-1:0] remain_reg, remain_next;
    logic [7:0]       id_reg,     id_next;
    logic [7:0]       type_reg,   type_next;
    logic [LEN_W-1:0] hlen_reg,   hlen_next;
    logic [31:0]      acc_reg,    acc_next;
    logic [2:0]       taken_reg,  taken_next;

    logic [PH_W-1:0]  ph;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] len_s;
    logic [15:0]      full;
    logic [LEN_W-1:0] left;
    logic             inc;

    always_comb
    begin
        phase_next  = phase_reg;
        total_next  = total_reg;
        remain_next = remain_reg;
        id_next     = id_reg;
        type_next   = type_reg;
        hlen_next   = hlen_reg;
        acc_next    = acc_reg;
        taken_next  = taken_reg;
        ph          = phase_reg;
        pos         = pos_reg;
        inc         = 1'b1;
        emit        = 1'b0;
        res         = '0;
        res.dp_id   = id_reg;
        res.dp_type = type_reg;
        full        = {hlen_reg[7:0], item.data_byte};

        // new message restarts length, position, counters, value and phase
        len_s = (32'(item.message_length) > MAX_MESSAGE_BYTES)
                ? LEN_W'(MAX_MESSAGE_BYTES) : item.message_length;
        if (item.first_byte)
        begin
            total_next  = len_s;
            pos         = '0;
            remain_next = '0;
            acc_next    = '0;
            taken_next  = '0;
            ph          = (item.status_report && len_s > LEN_W'(2)) ? PH_SKIP : PH_ID;
        end
        phase_next = ph;
        left       = total_next - pos - LEN_W'(1);

        case (ph)
            PH_SKIP:
            begin
                if (pos != '0)
                begin
                    phase_next = PH_ID;
                end
            end
            PH_ID:
            begin
                if ({1'b0, pos} + 11'd4 > {1'b0, total_next})
                begin
                    // truncated header, rest of message ignored
                    phase_next = PH_DROP;
                    inc        = 1'b0;
                end
                else
                begin
                    id_next    = item.data_byte;
                    phase_next = PH_TYPE;
                end
            end
            PH_TYPE:
            begin
                type_next  = item.data_byte;
                phase_next = PH_LENHI;
            end
            PH_LENHI:
            begin
                hlen_next  = {2'b00, item.data_byte};
                phase_next = PH_LENLO;
            end
            PH_LENLO:
            begin
                if (full > 16'(MAX_DP_LENGTH) || full > {6'b0, left})
                begin
                    emit           = 1'b1;
                    res.dp_length  = (full > 16'(MAX_MESSAGE_BYTES))
                                     ? LEN_W'(MAX_MESSAGE_BYTES) : full[LEN_W-1:0];
                    res.bad_length = 1'b1;
                    phase_next     = PH_DROP;
                    inc            = 1'b0;
                end
                else
                begin
                    hlen_next   = full[LEN_W-1:0];
                    acc_next    = '0;
                    taken_next  = '0;
                    remain_next = full[LEN_W-1:0];
                    if (full == 16'd0)
                    begin
                        emit       = 1'b1;
                        phase_next = PH_ID;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                if (taken_next < 3'd4)
                begin
                    acc_next   = {acc_next[23:0], item.data_byte};
                    taken_next = taken_next + 3'd1;
                end
                if (remain_next != '0)
                begin
                    remain_next = remain_next - LEN_W'(1);
                end
                if (remain_next == '0)
                begin
                    emit          = 1'b1;
                    res.dp_length = hlen_reg;
                    res.dp_value  = acc_next;
                    phase_next    = PH_ID;
                end
            end
            default:
            begin
                // idle or dropping: byte ignored
                inc = 1'b0;
            end
        endcase

        pos_next = inc ? pos + LEN_W'(1) : pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            pos_reg    <= '0;
            total_reg  <= '0;
            remain_reg <= '0;
            id_reg     <= '0;
            type_reg   <= '0;
            hlen_reg   <= '0;
            acc_reg    <= '0;
            taken_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            total_reg  <= total_next;
            remain_reg <= remain_next;
            id_reg     <= id_next;
            type_reg   <= type_next;
            hlen_reg   <= hlen_next;
            acc_reg    <= acc_next;
            taken_reg  <= taken_next;
        end
    end

endmodule

// ===== hw/rtl/dptlv_out_reg.sv =====
// result register: holds one datapoint until the receiver takes it
// depends on dptlv_pkg
module dptlv_out_reg
    import dptlv_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  logic    emit,
    input  result_t res_in,
    input  logic    ready,
    output logic    valid,
    output result_t res_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = emit;
        end
        else if (ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && emit)
        begin
            res_reg <= res_in;
        end
    end

    assign valid   = valid_reg;
    assign res_out = res_reg;

endmodule

// ===== hw/rtl/datapoint_tlv_parser.sv =====
// datapoint tlv parser
// splits a report payload, one byte per word, into datapoint results
// usage:
//   item:   one payload byte per word; first_byte marks the start of a message and
//           carries message_length and status_report for that message
//   result: one word per complete datapoint (id, type, length, first up to four
//           data bytes big-endian) or one error word with bad_length set, after
//           which the rest of the message is dropped; a truncated header emits nothing
// timing:
//   a byte is registered in the input register on acceptance and parsed from it;
//   its result, if any, is loaded into the result register when the stage advances
//   one byte per cycle sustained while result.ready does not stall the output; the
//   parse step between the input register and the result register is combinational
// stall:
//   while a result waits on result.ready, the parser holds the byte behind it and
//   item.ready falls once that input register is full; nothing is lost
// reset:
//   rst_n clears both stages and returns the parser to idle; bytes without
//   first_byte are ignored until a message starts
// depends on dptlv_pkg, dptlv_in_if, dptlv_out_if, dptlv_in_reg, dptlv_parse,
// dptlv_out_reg and datapoint_tlv_parser_macros.svh
`include "datapoint_tlv_parser_macros.svh"

module datapoint_tlv_parser
    import dptlv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    dptlv_in_if.sink    item,
    dptlv_out_if.source result
);

    item_t   item_in;
    item_t   stage_item;
    logic    stage_valid;
    logic    advance;
    logic    load_in;
    logic    emit;
    result_t parse_res;
    result_t out_res;

    // input side payload bundle
    assign item_in.data_byte      = item.data_byte;
    assign item_in.first_byte     = item.first_byte;
    assign item_in.message_length = item.message_length;
    assign item_in.status_report  = item.status_report;

    // stage moves on when the result register is empty or being drained
    assign advance    = stage_valid & (~result.valid | result.ready);
    assign item.ready = ~stage_valid | advance;
    assign load_in    = item.valid & item.ready;

    dptlv_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load_in),
        .item_in  (item_in),
        .take     (advance),
        .valid    (stage_valid),
        .item_out (stage_item)
    );

    dptlv_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .item  (stage_item),
        .emit  (emit),
        .res   (parse_res)
    );

    dptlv_out_reg u_out_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (advance),
        .emit    (emit),
        .res_in  (parse_res),
        .ready   (result.ready),
        .valid   (result.valid),
        .res_out (out_res)
    );

    // result side payload
    assign result.dp_id      = out_res.dp_id;
    assign result.dp_type    = out_res.dp_type;
    assign result.dp_length  = out_res.dp_length;
    assign result.dp_value   = out_res.dp_value;
    assign result.bad_length = out_res.bad_length;

    // error words never carry a value
    `DPTLV_ASSERT_IMP(a_bad_no_value, clk, rst_n,
        result.valid && result.bad_length,
        result.dp_value == 32'd0, "error result carries a value")
    // empty datapoints carry a zero value
    `DPTLV_ASSERT_IMP(a_empty_zero, clk, rst_n,
        result.valid && !result.bad_length && result.dp_length == '0,
        result.dp_value == 32'd0, "empty datapoint with nonzero value")
    // a full stage behind a stalled result blocks the input
    `DPTLV_ASSERT_IMP(a_stall_blocks, clk, rst_n,
        stage_valid && result.valid && !result.ready,
        !item.ready, "input taken while result stalled")
    // a parsed result shows up in the next cycle
    `DPTLV_ASSERT_NXT(a_emit_shows, clk, rst_n,
        advance && emit,
        result.valid, "emitted result lost")

endmodule
